[hdl/postfix_stack_evaluator_core_defines.svh]
// assertion macros shared by the evaluator rtl
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/pse_pkg.sv]
// package: field widths, codes and shared types of the postfix evaluator
package pse_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;
   localparam int DEFAULT_DATA_WIDTH  = 32;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int TOP_W    = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NEG  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_READ = 3'd6;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO  = 2'd3;

   // alu operations
   localparam logic [1:0] ALU_ADD = 2'd0;
   localparam logic [1:0] ALU_SUB = 2'd1;
   localparam logic [1:0] ALU_MUL = 2'd2;
   localparam logic [1:0] ALU_DIV = 2'd3;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_ctrl_type;

endpackage

[hdl/pse_channels.sv]
// interfaces: request and response channels of the postfix evaluator
interface pse_req_if import pse_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

interface pse_rsp_if import pse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TOP_W-1:0]  top_value;
   logic [STATUS_W-1:0]      status;
   logic [FILL_W-1:0]        fill;

   modport source (output valid, top_value, status, fill, input ready);
   modport sink   (input valid, top_value, status, fill, output ready);
endinterface

[hdl/pse_stack.sv]
// operand memory: one write port, one registered read port
module pse_stack import pse_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int DATA_WIDTH  = DEFAULT_DATA_WIDTH,
   localparam int ADDR_W     = $clog2(STACK_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pse_alu.sv]
// bit-serial alu: serial add/subtract, shift-add multiply, restoring divide
module pse_alu import pse_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_ctrl_type          ctrl,
   input  logic [DATA_WIDTH-1:0] left,
   input  logic [DATA_WIDTH-1:0] right,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RUN  = 2'd1;
   localparam logic [1:0] PH_FIX  = 2'd2;

   logic [1:0]            phase_ff, phase_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]            op_ff, op_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic                  carry_ff, carry_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;

   logic                  b_bit;
   logic                  sum_bit;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   trial;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;

      b_bit    = b_ff[0] ^ (op_ff == ALU_SUB);
      sum_bit  = a_ff[0] ^ b_bit ^ carry_ff;
      shifted  = {rem_ff, a_ff[DATA_WIDTH-1]};
      trial    = shifted - {1'b0, b_ff};

      unique case (phase_ff)
         PH_IDLE: begin
            if (ctrl.start) begin
               phase_in = PH_RUN;
               cnt_in   = CNT_LAST;
               op_in    = ctrl.op;
               acc_in   = '0;
               rem_in   = '0;
               carry_in = (ctrl.op == ALU_SUB);
               neg_in   = left[DATA_WIDTH-1] ^ right[DATA_WIDTH-1];
               if (ctrl.op == ALU_DIV) begin
                  a_in = left[DATA_WIDTH-1] ? '0 - left : left;
                  b_in = right[DATA_WIDTH-1] ? '0 - right : right;
               end else begin
                  a_in = left;
                  b_in = right;
               end
            end
         end
         PH_RUN: begin
            case (op_ff) inside
               ALU_ADD, ALU_SUB: begin
                  acc_in   = {sum_bit, acc_ff[DATA_WIDTH-1:1]};
                  carry_in = (a_ff[0] & b_bit) | (carry_ff & (a_ff[0] ^ b_bit));
                  a_in     = a_ff >> 1;
                  b_in     = b_ff >> 1;
               end
               ALU_MUL: begin
                  if (b_ff[0]) begin
                     acc_in = acc_ff + a_ff;
                  end
                  a_in = a_ff << 1;
                  b_in = b_ff >> 1;
               end
               default: begin
                  // restoring divide, one quotient bit a cycle
                  if (trial[DATA_WIDTH]) begin
                     rem_in = shifted[DATA_WIDTH-1:0];
                     a_in   = {a_ff[DATA_WIDTH-2:0], 1'b0};
                  end else begin
                     rem_in = trial[DATA_WIDTH-1:0];
                     a_in   = {a_ff[DATA_WIDTH-2:0], 1'b1};
                  end
               end
            endcase
            if (cnt_ff == '0) begin
               if (op_ff == ALU_DIV) begin
                  phase_in = PH_FIX;
               end else begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         PH_FIX: begin
            acc_in   = neg_ff ? '0 - a_ff : a_ff;
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

[hdl/postfix_stack_evaluator_core.sv]
// top level: postfix evaluator with operand memory, top register and serial alu
//
//   channel  | role   | transfer holds
//   ---------+--------+--------------------------------------
//   req_ch   | sink   | kind, value
//   rsp_ch   | source | top_value, status, fill
//
// push, read top, refused or no-op items pass from decode straight to finish
// add, subtract, multiply, negate and divide wait in exec for the alu, divide with
// a final sign-fix step; the bit-serial alu works one bit per cycle
// reset is synchronous: clears fill count and control, memory keeps its contents
// a result waits in the output register while the next item is taken; an item
// only stalls at its end if the previous result is still untaken
`include "postfix_stack_evaluator_core_defines.svh"

module postfix_stack_evaluator_core import pse_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int DATA_WIDTH  = DEFAULT_DATA_WIDTH
) (
   input  logic   clock,
   input  logic   reset,
   pse_req_if.sink   req_ch,
   pse_rsp_if.source rsp_ch
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   // controller states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_EXEC   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] top_ff, top_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  pop_ff, pop_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOP_W-1:0]      out_top_ff, out_top_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;
   logic [FILL_W-1:0]     out_fill_ff, out_fill_in;

   logic                  req_xfer;
   logic                  out_free;
   logic [63:0]           value_ext;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [DATA_WIDTH-1:0] second;

   alu_ctrl_type          alu_ctrl;
   logic [DATA_WIDTH-1:0] alu_left;
   logic                  alu_done;
   logic [DATA_WIDTH-1:0] alu_result;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // sign-extend from 32 bits, then keep the data width
   assign value_ext   = {{(64 - VALUE_W){req_ch.value[VALUE_W-1]}}, req_ch.value};

   // second from top sits just below the top register
   assign mem_rd_addr = ADDR_W'(count_ff - CNT_TWO);
   assign mem_wr_addr = ADDR_W'(count_ff - 1'b1);

   pse_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (top_ff),
      .rd_en   (req_xfer),
      .rd_addr (mem_rd_addr),
      .rd_data (second)
   );

   pse_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .left   (alu_left),
      .right  (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      pop_in        = pop_ff;
      mem_wr_en     = 1'b0;
      alu_ctrl      = '0;
      alu_left      = second;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_top_in    = out_top_ff;
      out_status_in = out_status_ff;
      out_fill_in   = out_fill_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_ch.kind;
               value_in = DATA_WIDTH'(value_ext);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = STATUS_OK;
            pop_in    = 1'b0;
            state_in  = S_FINISH;
            unique case (kind_ff) inside
               KIND_PUSH: begin
                  if (count_ff == CNT_FULL) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     // old top drops into memory
                     mem_wr_en = (count_ff != '0);
                     top_in    = value_ff;
                     count_in  = count_ff + 1'b1;
                  end
               end
               KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                  if (count_ff < CNT_TWO) begin
                     status_in = STATUS_UNDERFLOW;
                  end else if (kind_ff == KIND_DIV && top_ff == '0) begin
                     status_in = STATUS_DIV_ZERO;
                  end else begin
                     alu_ctrl.start = 1'b1;
                     pop_in         = 1'b1;
                     state_in       = S_EXEC;
                     unique case (kind_ff)
                        KIND_ADD: alu_ctrl.op = ALU_ADD;
                        KIND_SUB: alu_ctrl.op = ALU_SUB;
                        KIND_MUL: alu_ctrl.op = ALU_MUL;
                        default:  alu_ctrl.op = ALU_DIV;
                     endcase
                  end
               end
               KIND_NEG: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_UNDERFLOW;
                  end else begin
                     // negate as zero minus top
                     alu_ctrl.start = 1'b1;
                     alu_ctrl.op    = ALU_SUB;
                     alu_left       = '0;
                     state_in       = S_EXEC;
                  end
               end
               KIND_READ: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_UNDERFLOW;
                  end
               end
               default: begin
                  // unused kind: nothing changes
               end
            endcase
         end
         S_EXEC: begin
            if (alu_done) begin
               top_in   = alu_result;
               state_in = S_FINISH;
               if (pop_ff) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_top_in    = (count_ff == '0) ? '0 : TOP_W'(top_ff);
               out_status_in = status_ff;
               out_fill_in   = FILL_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      pop_ff        <= pop_in;
      out_top_ff    <= out_top_in;
      out_status_ff <= out_status_in;
      out_fill_ff   <= out_fill_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.top_value = out_top_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.fill      = out_fill_ff;

   // fill count never passes the depth
   `PSE_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, count_ff <= CNT_FULL, "fill beyond depth")

   // alu finishes only while the controller waits for it
   `PSE_ASSERT_IMPLY(a_done_in_exec, clock, reset, alu_done, state_ff == S_EXEC, "stray alu done")

   // memory is written only by a push onto a partly filled stack
   `PSE_ASSERT_IMPLY(a_push_write, clock, reset, mem_wr_en, kind_ff == KIND_PUSH && count_ff != '0 && count_ff != CNT_FULL, "bad memory write")

   // an accepted item is decoded next and blocks further transfers
   `PSE_ASSERT_NEXT(a_accept_decode, clock, reset, req_xfer, state_ff == S_DECODE && !req_ch.ready, "accept not followed by decode")

endmodule

[bench/postfix_stack_evaluator_core_test.sv]
// testbench for the postfix evaluator: shadow operand stack, burst stimulus, stalling sink
`timescale 1ns / 100ps

// shadow of the operand stack and the queue of outcomes still to arrive
class stack_shadow;
   typedef struct packed {
      logic [pse_pkg::TOP_W-1:0]    top_value;
      logic [pse_pkg::STATUS_W-1:0] status;
      logic [pse_pkg::FILL_W-1:0]   fill;
   } outcome_type;

   logic [pse_pkg::DEFAULT_DATA_WIDTH-1:0] entries [pse_pkg::DEFAULT_STACK_DEPTH];
   int          depth_used;
   int          errors;
   outcome_type awaited [$];

   function new();
      depth_used = 0;
      errors     = 0;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   // evaluate one accepted item and queue the outcome it must produce
   function void take_item(logic [pse_pkg::KIND_W-1:0] kind,
                           logic [pse_pkg::VALUE_W-1:0] value);
      logic [pse_pkg::DEFAULT_DATA_WIDTH-1:0] lhs, rhs, lmag, rmag, quot, res;
      logic [pse_pkg::STATUS_W-1:0] status;
      outcome_type outcome;
      status = pse_pkg::STATUS_OK;
      case (kind) inside
         pse_pkg::KIND_PUSH: begin
            if (depth_used >= pse_pkg::DEFAULT_STACK_DEPTH) begin
               status = pse_pkg::STATUS_OVERFLOW;
            end else begin
               entries[depth_used] = value;
               depth_used++;
            end
         end
         pse_pkg::KIND_ADD, pse_pkg::KIND_SUB, pse_pkg::KIND_MUL, pse_pkg::KIND_DIV: begin
            if (depth_used < 2) begin
               status = pse_pkg::STATUS_UNDERFLOW;
            end else begin
               rhs = entries[depth_used-1];
               lhs = entries[depth_used-2];
               res = '0;
               if (kind == pse_pkg::KIND_ADD) begin
                  res = lhs + rhs;
               end else if (kind == pse_pkg::KIND_SUB) begin
                  res = lhs - rhs;
               end else if (kind == pse_pkg::KIND_MUL) begin
                  res = lhs * rhs;
               end else if (rhs != '0) begin
                  // magnitudes then sign, so the most negative over minus one wraps
                  lmag = lhs[$bits(lhs)-1] ? -lhs : lhs;
                  rmag = rhs[$bits(rhs)-1] ? -rhs : rhs;
                  quot = lmag / rmag;
                  res  = (lhs[$bits(lhs)-1] ^ rhs[$bits(rhs)-1]) ? -quot : quot;
               end
               if (kind == pse_pkg::KIND_DIV && rhs == '0) begin
                  status = pse_pkg::STATUS_DIV_ZERO;
               end else begin
                  depth_used--;
                  entries[depth_used-1] = res;
               end
            end
         end
         pse_pkg::KIND_NEG: begin
            if (depth_used < 1) status = pse_pkg::STATUS_UNDERFLOW;
            else entries[depth_used-1] = -entries[depth_used-1];
         end
         pse_pkg::KIND_READ: begin
            if (depth_used < 1) status = pse_pkg::STATUS_UNDERFLOW;
         end
         default: ;
      endcase
      outcome.top_value = (depth_used != 0) ? entries[depth_used-1] : '0;
      outcome.status    = status;
      outcome.fill      = depth_used[pse_pkg::FILL_W-1:0];
      awaited.push_back(outcome);
   endfunction

   function void check_result(logic [pse_pkg::TOP_W-1:0] top_value,
                              logic [pse_pkg::STATUS_W-1:0] status,
                              logic [pse_pkg::FILL_W-1:0] fill);
      outcome_type want;
      if (awaited.size() == 0) begin
         $error("result with nothing awaited: top_value %0d status %0d fill %0d",
                $signed(top_value), status, fill);
         errors++;
         return;
      end
      want = awaited.pop_front();
      if (top_value !== want.top_value) begin
         $error("top_value: expected %0d, got %0d", $signed(want.top_value),
                $signed(top_value));
         errors++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         errors++;
      end
      if (fill !== want.fill) begin
         $error("fill: expected %0d, got %0d", want.fill, fill);
         errors++;
      end
   endfunction
endclass

module postfix_stack_evaluator_core_test;
   import pse_pkg::*;

   // kind 7 does nothing, it is not among the package codes
   localparam logic [KIND_W-1:0]  KIND_NOP  = 3'd7;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] VALUE_M1  = 32'hffff_ffff;
   localparam int RANDOM_ITEMS = 1100;
   localparam int TAIL_CYCLES  = 40;

   // receiver behaviour, changed every so often
   typedef enum int {SINK_OPEN, SINK_EAGER, SINK_SLUGGISH, SINK_BLOCKED} sink_mode_type;

   logic clock = 1'b0;
   logic reset;

   pse_req_if req_ch ();
   pse_rsp_if rsp_ch ();

   stack_shadow sb;
   int burst_left;
   int items_sent;

   postfix_stack_evaluator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // offer one item, hold it until the transfer, then maybe leave a gap
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_item(kind, value);
      if (kind != KIND_NOP) items_sent++;
      // end of burst: drop valid for a while, now and then a long gapless stretch follows
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
      end
   endtask

   // hold off the sender until every outcome has come back
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // mostly extremes, zeros and small numbers so that divide does something useful
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return VALUE_M1;
         4, 5: return $urandom_range(0, 40) - 20;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pick_binary();
      case ($urandom_range(0, 3))
         0: return KIND_ADD;
         1: return KIND_SUB;
         2: return KIND_MUL;
         default: return KIND_DIV;
      endcase
   endfunction

   // pops everything it can, then one operation too many and a negate or a read
   task automatic drain_stack();
      while (sb.depth_used >= 2) send_item(pick_binary(), $urandom());
      send_item(pick_binary(), $urandom());
      if ($urandom_range(0, 1) == 0) send_item(KIND_NEG, $urandom());
      else send_item(KIND_READ, $urandom());
   endtask

   initial begin : stimulus
      int choice, n, i;
      sb = new();
      burst_left = 0;
      items_sent = 0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind  = KIND_PUSH;
      req_ch.value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty stack first
      send_item(KIND_READ, VALUE_M1);
      send_item(KIND_NEG, '0);
      send_item(KIND_ADD, VALUE_MAX);
      send_item(KIND_NOP, VALUE_MIN);
      // one operand only, then most negative over minus one and its negation
      send_item(KIND_PUSH, VALUE_MIN);
      send_item(KIND_DIV, '0);
      send_item(KIND_PUSH, VALUE_M1);
      send_item(KIND_DIV, '0);
      send_item(KIND_NEG, '0);
      // divide by zero leaves both operands
      send_item(KIND_PUSH, '0);
      send_item(KIND_DIV, '0);
      send_item(KIND_ADD, '0);
      // add and multiply with the largest positive value
      send_item(KIND_PUSH, VALUE_MAX);
      send_item(KIND_ADD, '0);
      send_item(KIND_PUSH, VALUE_MAX);
      send_item(KIND_MUL, '0);
      // quotient truncated toward zero
      send_item(KIND_PUSH, -32'sd7);
      send_item(KIND_PUSH, 32'sd2);
      send_item(KIND_DIV, '0);
      send_item(KIND_SUB, '0);
      send_item(KIND_READ, '0);
      send_item(KIND_NOP, VALUE_M1);
      wait_drain();

      // random: mostly well-formed expressions, some brim-fills, drains and noise
      while (items_sent < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 99);
         if (choice < 55 && sb.depth_used <= 12) begin
            n = $urandom_range(2, 4);
            for (i = 0; i < n; i++) begin
               send_item(KIND_PUSH, pick_value());
               if ($urandom_range(0, 5) == 0) send_item(KIND_NEG, $urandom());
               if ($urandom_range(0, 7) == 0) send_item(KIND_READ, $urandom());
            end
            for (i = 0; i < n - 1; i++) send_item(pick_binary(), $urandom());
         end else if (choice < 70) begin
            // fill to the brim and push past it
            while (sb.depth_used < DEFAULT_STACK_DEPTH) send_item(KIND_PUSH, pick_value());
            repeat ($urandom_range(1, 3)) send_item(KIND_PUSH, pick_value());
            send_item(KIND_READ, $urandom());
         end else if (choice < 85) begin
            drain_stack();
         end else begin
            repeat ($urandom_range(1, 6)) send_item(KIND_W'($urandom_range(0, 7)), $urandom());
         end
         if ($urandom_range(0, 39) == 0) wait_drain();
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // result side: check each transfer, then pick the next ready
   initial begin : result_sink
      sink_mode_type mode;
      int mode_left;
      mode = SINK_OPEN;
      mode_left = 50;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.top_value, rsp_ch.status, rsp_ch.fill);
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            // a blocked spell stays short, the others run for a while
            mode_left = (mode == SINK_BLOCKED) ? $urandom_range(1, 20) : $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (mode)
            SINK_OPEN:     rsp_ch.ready <= 1'b1;
            SINK_EAGER:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            SINK_SLUGGISH: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:       rsp_ch.ready <= 1'b0;
         endcase
      end
   end

   // watchdog, well beyond the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
